// ----- design/assert_macros.svh -----
// Assertion macros shared by the display writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk, disabled while rst_n is low.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed in display writer");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed in display writer");

`endif

// ----- design/snd_pkg.sv -----
// Package with types and constants of the signed number display writer.
package snd_pkg;

  localparam int BIN_W      = 64;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W      = 4 * BCD_DIGITS;

  localparam logic [4:0] SYM_MINUS = 5'd25;
  localparam logic [4:0] SYM_BLANK = 5'd31;
  localparam logic [4:0] SYM_ERR_A = 5'd17;
  localparam logic [4:0] SYM_ERR_B = 5'd19;

  localparam logic [4:0] KEEP_POS = 5'd4;
  localparam logic [4:0] KEEP_NEG = 5'd3;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_NORM = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // Command to the shared shift unit.
  typedef struct packed {
    logic load;
    logic dabble;
    logic norm;
  } unit_cmd_t;

endpackage

// ----- design/snd_ifs.sv -----
// Valid/ready channel interfaces for input and result items.
interface snd_in_if;
  logic               valid;
  logic               ready;
  logic               chip;
  logic [1:0]         display;
  logic signed [63:0] number;

  modport source (output valid, chip, display, number, input ready);
  modport sink   (input valid, chip, display, number, output ready);
endinterface

interface snd_out_if;
  logic       valid;
  logic       ready;
  logic       target_chip;
  logic [3:0] digit_register;
  logic [4:0] symbol;
  logic       decimal_point;
  logic       last;

  modport source (output valid, target_chip, digit_register, symbol, decimal_point, last,
                  input ready);
  modport sink   (input valid, target_chip, digit_register, symbol, decimal_point, last,
                  output ready);
endinterface

// ----- design/signed_number_to_four_digit_display.sv -----
// Top level of the signed number to four-digit display writer.
//
// One input item carries a chip select, a display half and a signed 64-bit
// number. For a display half of zero or one the block emits four result items,
// the digit-register writes for digits 1..4 or 5..8, the fourth marked last.
// An item with a display half above one is taken and produces nothing.
// The magnitude is converted to 20 BCD digits by a shift-and-add-three unit,
// one bit per cycle. The same unit then shifts the digits left one digit per
// cycle until the leading digit is nonzero or only the kept digits remain,
// which yields the count of digits left. The first result is valid once
// normalization ends, and the four results then follow one per cycle while
// the receiver takes them. The input is ready only when the block is idle
// and no result is pending, so a new item is taken only after the last
// result of the previous one has been taken. When the receiver stalls, the
// current result holds and the block waits. Reset (rst_n low, synchronous)
// returns the block to idle with no result pending; the conversion registers
// need no reset.
`include "assert_macros.svh"

module signed_number_to_four_digit_display import snd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  snd_in_if.sink   in_ch,
  snd_out_if.source out_ch
);

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [4:0] sh_r, sh_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       chip_r, chip_nxt;
  logic       disp_r, disp_nxt;
  logic       neg_r, neg_nxt;
  logic       err_r, err_nxt;
  logic [3:0] expo_r, expo_nxt;

  unit_cmd_t        cmd;
  logic [BIN_W-1:0] mag;
  logic [3:0]       top_digit;
  logic [15:0]      top_four;
  logic [4:0]       remaining;
  logic [4:0]       keep;
  logic             norm_done;
  logic             in_fire;

  assign in_ch.ready = (state_r == ST_IDLE) && !out_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Magnitude of the two's complement input.
  assign mag = in_ch.number[BIN_W-1] ? (BIN_W'(0) - in_ch.number) : in_ch.number;

  // Normalization stops at the first nonzero leading digit, or once only the
  // kept digits are left, so short numbers come out zero padded.
  assign remaining = 5'(BCD_DIGITS) - sh_r;
  assign keep      = neg_r ? KEEP_NEG : KEEP_POS;
  assign norm_done = (top_digit != 4'd0) || (remaining == keep);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sh_nxt        = sh_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    chip_nxt      = chip_r;
    disp_nxt      = disp_r;
    neg_nxt       = neg_r;
    err_nxt       = err_r;
    expo_nxt      = expo_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && !in_ch.display[1]) begin
          cmd.load  = 1'b1;
          chip_nxt  = in_ch.chip;
          disp_nxt  = in_ch.display[0];
          neg_nxt   = in_ch.number[BIN_W-1];
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.dabble = 1'b1;
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r == 6'(BIN_W - 1)) begin
          sh_nxt    = '0;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_done) begin
          // Nineteen or more digits on a negative number is out of range.
          err_nxt       = neg_r && (sh_r <= 5'd1);
          expo_nxt      = 4'(remaining - keep);
          pos_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_EMIT;
        end else begin
          cmd.norm = 1'b1;
          sh_nxt   = sh_r + 5'd1;
        end
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          if (pos_r == 2'd3) begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            pos_nxt = pos_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sh_r        <= '0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      sh_r        <= sh_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chip_r <= chip_nxt;
    disp_r <= disp_nxt;
    neg_r  <= neg_nxt;
    err_r  <= err_nxt;
    expo_r <= expo_nxt;
  end

  snd_shift_unit u_shift (
    .clk       (clk),
    .cmd       (cmd),
    .load_mag  (mag),
    .top_digit (top_digit),
    .top_four  (top_four)
  );

  snd_glyph u_glyph (
    .pos           (pos_r),
    .neg           (neg_r),
    .err           (err_r),
    .expo          (expo_r),
    .top_four      (top_four),
    .symbol        (out_ch.symbol),
    .decimal_point (out_ch.decimal_point)
  );

  // The result fields decode held registers only, so they stay put on a stall.
  assign out_ch.valid          = out_valid_r;
  assign out_ch.target_chip    = chip_r;
  assign out_ch.digit_register = {1'b0, disp_r, pos_r} + 4'd1;
  assign out_ch.last           = (pos_r == 2'd3);

  `ASSERT_ALWAYS(a_ready_no_pending, in_ch.ready |-> !out_valid_r)
  `ASSERT_CLK(a_valid_in_emit, out_valid_r |-> (state_r == ST_EMIT))
  `ASSERT_CLK(a_last_frees_input,
              (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)

endmodule

// ----- design/snd_shift_unit.sv -----
// Shared shift unit: serial binary to BCD conversion and digit normalization.
module snd_shift_unit import snd_pkg::*; (
  input  logic             clk,
  input  unit_cmd_t        cmd,
  input  logic [BIN_W-1:0] load_mag,
  output logic [3:0]       top_digit,
  output logic [15:0]      top_four
);

  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] bcd_adj;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (cmd.load) begin
      bin_nxt = load_mag;
      bcd_nxt = '0;
    end else if (cmd.dabble) begin
      bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[BIN_W-1]};
    end else if (cmd.norm) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];
  assign top_four  = bcd_r[BCD_W-1 -: 16];

endmodule

// ----- design/snd_glyph.sv -----
// Symbol and decimal point selection for one digit position.
module snd_glyph import snd_pkg::*; (
  input  logic [1:0]  pos,
  input  logic        neg,
  input  logic        err,
  input  logic [3:0]  expo,
  input  logic [15:0] top_four,
  output logic [4:0]  symbol,
  output logic        decimal_point
);

  logic [3:0] digit_pos;
  logic [3:0] digit_prev;

  always_comb begin
    case (pos)
      2'd0:    digit_pos = top_four[15:12];
      2'd1:    digit_pos = top_four[11:8];
      2'd2:    digit_pos = top_four[7:4];
      default: digit_pos = top_four[3:0];
    endcase
    case (pos)
      2'd1:    digit_prev = top_four[15:12];
      2'd2:    digit_prev = top_four[11:8];
      default: digit_prev = top_four[7:4];
    endcase
  end

  always_comb begin
    if (err) begin
      case (pos)
        2'd0:    symbol = SYM_MINUS;
        2'd1:    symbol = SYM_BLANK;
        2'd2:    symbol = SYM_ERR_A;
        default: symbol = SYM_ERR_B;
      endcase
      decimal_point = 1'b0;
    end else begin
      if (neg) begin
        symbol = (pos == 2'd0) ? SYM_MINUS : {1'b0, digit_prev};
      end else begin
        symbol = {1'b0, digit_pos};
      end
      decimal_point = expo[2'd3 - pos];
    end
  end

endmodule
